/* rtl/u16u8_pkg.sv */
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CP_W     = 21;
	localparam int LEN_W    = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_HIGH_END   = 2'd1,
		ST_UNP_HIGH   = 2'd2,
		ST_UNP_LOW    = 2'd3
	} status_t;

	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;

	localparam logic [CP_W-1:0] SUPP_BASE = 21'h01_0000;
	localparam logic [CP_W-1:0] MAX_1BYTE = 21'h00_007F;
	localparam logic [CP_W-1:0] MAX_2BYTE = 21'h00_07FF;
	localparam logic [CP_W-1:0] MAX_3BYTE = 21'h00_FFFF;

	// len 0 means a single bare result with no byte (marker or error)
	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic [LEN_W-1:0] len;
		status_t          status;
		logic             str_end;
	} job_t;

endpackage

/* rtl/utf16_to_utf8_transcoder.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and
// strict or ignore handling of invalid surrogates.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  input   | push / full              | code_unit, unit_last
//  result  | pop / empty              | out_byte, byte_valid, run_last,
//          |                          | string_end, status
//  config  | cfg_valid / cfg_ready    | ignore_invalid
//
//  a unit is accepted on push while full is low; it yields zero to four
//  results, which leave the byte-wide output register of the back end at
//  one per cycle while pop is held high and jobs are queued
//  reset clears surrogate, discard and queue state and the mode register
//  full rises only when the job queue (QUEUE_DEPTH jobs) is full
//  a stalled pop holds the output register while the front keeps filling
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder
	import u16u8_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        ignore_invalid,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        unit_last,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        string_end,
	output logic [1:0]  status
);

	logic q_full, q_empty, q_push, q_pop;
	job_t q_wdata, q_rdata;

	u16u8_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.ignore_invalid (ignore_invalid),
		.push           (push),
		.full           (full),
		.code_unit      (code_unit),
		.unit_last      (unit_last),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wdata)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_data (q_rdata)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end),
		.status     (status)
	);

endmodule

/* rtl/u16u8_front.sv */
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks surrogate and discard state, queues one job
// per unit that yields results.
// ----------------------------------------------------------------------------
module u16u8_front
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        ignore_invalid,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        unit_last,
	input  logic        q_full,
	output logic        q_push,
	output job_t        q_data
);

	logic       ign_q;
	logic       held_q;
	logic [9:0] held_bits_q;
	logic       disc_q;

	logic       accept;
	logic       is_hi, is_lo;
	logic       err, have, paired, emit;
	status_t    status;
	logic [CP_W-1:0] cp;
	logic       held_n, disc_n;
	logic [9:0] held_bits_n;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;
	assign is_hi     = (code_unit[15:10] == HI_SURR_TAG);
	assign is_lo     = (code_unit[15:10] == LO_SURR_TAG);

	always_comb begin
		err         = 1'b0;
		have        = 1'b0;
		paired      = 1'b0;
		emit        = 1'b0;
		status      = ST_OK;
		cp          = '0;
		held_n      = held_q;
		held_bits_n = held_bits_q;
		disc_n      = disc_q;
		if (disc_q) begin
			if (unit_last) begin
				disc_n = 1'b0;
			end
		end else begin
			if (held_q) begin
				held_n = 1'b0;
				if (is_lo) begin
					cp     = SUPP_BASE + {1'b0, held_bits_q, code_unit[9:0]};
					have   = 1'b1;
					paired = 1'b1;
				end else if (!ign_q) begin
					err    = 1'b1;
					status = ST_UNP_HIGH;
				end
			end
			if (!err && !paired) begin
				if (is_hi) begin
					if (unit_last) begin
						if (!ign_q) begin
							err    = 1'b1;
							status = ST_HIGH_END;
						end
					end else begin
						held_bits_n = code_unit[9:0];
						held_n      = 1'b1;
					end
				end else if (is_lo) begin
					if (!ign_q) begin
						err    = 1'b1;
						status = ST_UNP_LOW;
					end
				end else begin
					cp   = {5'b0, code_unit};
					have = 1'b1;
				end
			end
			if (err) begin
				held_n = 1'b0;
				disc_n = !unit_last;
				emit   = 1'b1;
			end else begin
				emit = have || unit_last;
				if (unit_last) begin
					held_n = 1'b0;
				end
			end
		end
	end

	always_comb begin
		q_data.cp      = cp;
		q_data.status  = status;
		q_data.str_end = err || unit_last;
		if (err || !have) begin
			q_data.len = 3'd0;
		end else if (cp <= MAX_1BYTE) begin
			q_data.len = 3'd1;
		end else if (cp <= MAX_2BYTE) begin
			q_data.len = 3'd2;
		end else if (cp <= MAX_3BYTE) begin
			q_data.len = 3'd3;
		end else begin
			q_data.len = 3'd4;
		end
	end

	assign q_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_q       <= 1'b0;
			held_q      <= 1'b0;
			held_bits_q <= '0;
			disc_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ign_q <= ignore_invalid;
			end
			if (accept) begin
				held_q      <= held_n;
				held_bits_q <= held_bits_n;
				disc_q      <= disc_n;
			end
		end
	end

	a_disc_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		!(disc_q && held_q))
		else $error("discarding while a high surrogate is held");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && unit_last) |=> (!held_q && !disc_q))
		else $error("state left over after the last unit");

endmodule

/* rtl/u16u8_queue.sv */
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module u16u8_queue
	import u16u8_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	output logic q_full,
	input  logic rd_en,
	output logic q_empty,
	output job_t rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign q_full  = (count_q == FULL_CNT);
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

endmodule

/* rtl/u16u8_back.sv */
// ----------------------------------------------------------------------------
// u16u8_back
// Expands each queued job into its UTF-8 bytes or one bare result, one
// result per cycle while the output is popped, into a single output register.
// ----------------------------------------------------------------------------
module u16u8_back
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_data,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       string_end,
	output logic [STATUS_W-1:0] status
);

	logic [1:0] idx_q;
	logic       out_v_q;
	logic [7:0] byte_q;
	logic       bvalid_q, rlast_q, send_q;
	status_t    status_q;

	logic       load, res_last;
	logic [7:0] byte_n;
	logic [CP_W-1:0] cp;

	assign cp   = q_data.cp;
	assign load = !q_empty && (!out_v_q || pop);
	assign res_last = (q_data.len == 3'd0) || (({1'b0, idx_q} + 3'd1) == q_data.len);
	assign q_pop = load && res_last;

	always_comb begin
		unique case (q_data.len)
			3'd1: byte_n = {1'b0, cp[6:0]};
			3'd2: byte_n = (idx_q == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				unique case (idx_q)
					2'd0:    byte_n = {4'b1110, cp[15:12]};
					2'd1:    byte_n = {2'b10, cp[11:6]};
					default: byte_n = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				unique case (idx_q)
					2'd0: byte_n = {5'b11110, cp[20:18]};
					2'd1: byte_n = {2'b10, cp[17:12]};
					2'd2: byte_n = {2'b10, cp[11:6]};
					2'd3: byte_n = {2'b10, cp[5:0]};
				endcase
			end
			default: byte_n = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_n;
			bvalid_q <= (q_data.len != 3'd0);
			rlast_q  <= res_last;
			send_q   <= res_last && q_data.str_end;
			status_q <= (q_data.len == 3'd0) ? q_data.status : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= res_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign empty      = !out_v_q;
	assign out_byte   = byte_q;
	assign byte_valid = bvalid_q;
	assign run_last   = rlast_q;
	assign string_end = send_q;
	assign status     = status_q;

	a_mid_job_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !q_empty)
		else $error("byte index moved but no job at the head");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && send_q) |-> rlast_q)
		else $error("string end on a result that is not the unit's last");

	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q != ST_OK) |-> (!bvalid_q && send_q))
		else $error("error result carries a byte or leaves the string open");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A directed table
// covers byte-length boundaries, surrogate pairs, every error status in
// strict mode and ignore mode. Random strings follow, mostly well formed
// with some broken surrogates. Both queue sides idle at random, and one
// long result-side hold fills the block. Every result is checked against
// the table or an in-bench transcoder model.
// ----------------------------------------------------------------------------
module tb_top
	import u16u8_pkg::*;
();

	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       run_last;
		logic       str_end;
		status_t    st;
	} result_t;

	typedef enum {EXP_PRED, EXP_NONE, EXP_BYTES, EXP_BARE} exp_kind_t;

	typedef struct {
		logic        mode;
		logic [15:0] cu;
		logic        lst;
		exp_kind_t   kind;
		int          len;
		logic [31:0] bytes;
		status_t     st;
	} unit_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        ignore_invalid;
	logic        push;
	logic        full;
	logic [15:0] code_unit;
	logic        unit_last;
	logic        pop;
	logic        empty;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic        string_end;
	logic [1:0]  status;

	// transcoder model state
	logic       lenient;
	logic [9:0] hi_bits;
	logic       hi_held;
	logic       dropping;

	result_t utf8_due[$];
	int      mismatches;
	int      units_sent;
	int      results_seen;
	int      strings_sent;
	int      cfg_writes;
	int      cycle_cnt;
	bit      hold_req;

	utf16_to_utf8_transcoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.ignore_invalid(ignore_invalid),
		.push          (push),
		.full          (full),
		.code_unit     (code_unit),
		.unit_last     (unit_last),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.run_last      (run_last),
		.string_end    (string_end),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				utf8_due.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic unit_row_t drow(input logic mode, input logic [15:0] cu,
			input logic lst, input exp_kind_t kind, input int len,
			input logic [31:0] bytes, input status_t st);
		unit_row_t r;
		r.mode  = mode;
		r.cu    = cu;
		r.lst   = lst;
		r.kind  = kind;
		r.len   = len;
		r.bytes = bytes;
		r.st    = st;
		return r;
	endfunction

	function automatic void due_add(input result_t r);
		utf8_due = {utf8_due, r};
	endfunction

	// one code unit through the model; fills res with the results it causes
	function automatic void transcode_unit(input logic [15:0] cu, input logic lst,
			output result_t res [4], output int n);
		logic        is_hi;
		logic        is_lo;
		logic        have;
		logic        err;
		logic [20:0] cp;
		status_t     st;
		n     = 0;
		have  = 1'b0;
		err   = 1'b0;
		cp    = '0;
		st    = ST_OK;
		is_hi = cu[15:10] == HI_SURR_TAG;
		is_lo = cu[15:10] == LO_SURR_TAG;
		if (dropping) begin
			if (lst)
				dropping = 1'b0;
			return;
		end
		if (hi_held) begin
			hi_held = 1'b0;
			if (is_lo) begin
				cp   = SUPP_BASE + {1'b0, hi_bits, cu[9:0]};
				have = 1'b1;
			end else if (!lenient) begin
				err = 1'b1;
				st  = ST_UNP_HIGH;
			end
		end
		if (!err && !have) begin
			if (is_hi) begin
				if (!lst) begin
					hi_bits = cu[9:0];
					hi_held = 1'b1;
				end else if (!lenient) begin
					err = 1'b1;
					st  = ST_HIGH_END;
				end
			end else if (is_lo) begin
				if (!lenient) begin
					err = 1'b1;
					st  = ST_UNP_LOW;
				end
			end else begin
				cp   = {5'd0, cu};
				have = 1'b1;
			end
		end
		if (err) begin
			// error closes the string; rest of it is swallowed unless this was the end
			hi_held  = 1'b0;
			res[0]   = '{8'h00, 1'b0, 1'b1, 1'b1, st};
			n        = 1;
			dropping = !lst;
			return;
		end
		if (have) begin
			if (cp <= MAX_1BYTE) begin
				res[0].data = {1'b0, cp[6:0]};
				n = 1;
			end else if (cp <= MAX_2BYTE) begin
				res[0].data = {3'b110, cp[10:6]};
				res[1].data = {2'b10, cp[5:0]};
				n = 2;
			end else if (cp <= MAX_3BYTE) begin
				res[0].data = {4'b1110, cp[15:12]};
				res[1].data = {2'b10, cp[11:6]};
				res[2].data = {2'b10, cp[5:0]};
				n = 3;
			end else begin
				res[0].data = {5'b11110, cp[20:18]};
				res[1].data = {2'b10, cp[17:12]};
				res[2].data = {2'b10, cp[11:6]};
				res[3].data = {2'b10, cp[5:0]};
				n = 4;
			end
			for (int i = 0; i < n; i++) begin
				res[i].valid    = 1'b1;
				res[i].run_last = 1'b0;
				res[i].str_end  = 1'b0;
				res[i].st       = ST_OK;
			end
		end
		// bare end marker when the last unit yields no byte
		if (n == 0 && lst) begin
			res[0] = '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK};
			n = 1;
		end
		if (n > 0) begin
			res[n-1].run_last = 1'b1;
			res[n-1].str_end  = lst;
		end
		if (lst)
			hi_held = 1'b0;
	endfunction

	task automatic send_unit(input unit_row_t r, input int gap);
		result_t got [4];
		int      n;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		code_unit <= r.cu;
		unit_last <= r.lst;
		@(posedge clk);
		while (full)
			@(posedge clk);
		units_sent++;
		transcode_unit(r.cu, r.lst, got, n);
		case (r.kind)
			EXP_PRED: begin
				for (int i = 0; i < n; i++)
					due_add(got[i]);
			end
			EXP_BYTES: begin
				for (int i = 0; i < r.len; i++)
					due_add('{r.bytes[31-8*i -: 8], 1'b1, i == r.len - 1,
						r.lst && i == r.len - 1, ST_OK});
			end
			EXP_BARE: begin
				due_add('{8'h00, 1'b0, 1'b1, 1'b1, r.st});
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_free(input logic [15:0] cu, input logic lst, input int gap_max);
		send_unit(drow(lenient, cu, lst, EXP_PRED, 0, '0, ST_OK), $urandom_range(0, gap_max));
	endtask

	// wait for every expected result, then let the back end go quiet
	task automatic drain_and_settle();
		@(negedge clk);
		push <= 1'b0;
		while (utf8_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		drain_and_settle();
		@(negedge clk);
		cfg_valid      <= 1'b1;
		ignore_invalid <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		lenient = m;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random string: mostly valid code points and pairs, sometimes broken surrogates
	task automatic send_string(input int span, input bit noisy);
		int          left;
		int          gap_max;
		logic [15:0] cu;
		left    = span;
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
		strings_sent++;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: cu = 16'($urandom_range(0, 16'h007F));
				3, 4:    cu = 16'($urandom_range(16'h0080, 16'h07FF));
				5, 6: begin
					if ($urandom_range(0, 1))
						cu = 16'($urandom_range(16'h0800, 16'hD7FF));
					else
						cu = 16'($urandom_range(16'hE000, 16'hFFFF));
				end
				7, 8: begin
					if (left > 1) begin
						send_free(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0, gap_max);
						left--;
						cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
					end else begin
						cu = 16'($urandom_range(0, 16'h007F));
					end
				end
				default: begin
					if (!noisy)
						cu = 16'($urandom_range(0, 16'h007F));
					else if ($urandom_range(0, 2) == 0)
						cu = 16'($urandom_range(16'hD800, 16'hDBFF));
					else if ($urandom_range(0, 1) == 0)
						cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
					else
						cu = 16'($urandom());
				end
			endcase
			send_free(cu, left == 1, gap_max);
			left--;
		end
	endtask

	initial begin : result_side
		result_t got;
		result_t want;
		int      stall;
		int      quiet_left;
		bit      hold_done;
		pop        = 1'b0;
		quiet_left = 0;
		hold_done  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				@(negedge clk);
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			if (quiet_left > 0) begin
				stall = 0;
				quiet_left--;
			end else if ($urandom_range(0, 15) == 0) begin
				stall = 0;
				quiet_left = 24;
			end else begin
				stall = $urandom_range(0, 16);
			end
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got = '{out_byte, byte_valid, run_last, string_end, status_t'(status)};
			results_seen++;
			if (utf8_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected item byte %h valid %b last %b end %b status %0d",
						$realtime, got.data, got.valid, got.run_last, got.str_end, got.st);
			end else begin
				want = utf8_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp byte %h valid %b last %b end %b status %0d, %s",
							$realtime, want.data, want.valid, want.run_last, want.str_end,
							want.st, $sformatf("got byte %h valid %b last %b end %b status %0d",
							got.data, got.valid, got.run_last, got.str_end, got.st));
				end
			end
		end
	end

	initial begin : unit_side
		unit_row_t dir_tab[$];
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		ignore_invalid = 1'b0;
		push           = 1'b0;
		code_unit      = '0;
		unit_last      = 1'b0;
		lenient        = 1'b0;
		hi_bits        = '0;
		hi_held        = 1'b0;
		dropping       = 1'b0;
		hold_req       = 1'b0;
		mismatches     = 0;
		units_sent     = 0;
		results_seen   = 0;
		strings_sent   = 0;
		cfg_writes     = 0;
		cycle_cnt      = 0;

		// strict mode from reset: length boundaries, pairs, every error status
		dir_tab = {dir_tab, drow(1'b0, 16'h0000, 1'b0, EXP_BYTES, 1, 32'h0000_0000, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'h007F, 1'b0, EXP_BYTES, 1, 32'h7F00_0000, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'h0080, 1'b0, EXP_BYTES, 2, 32'hC280_0000, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'h07FF, 1'b0, EXP_BYTES, 2, 32'hDFBF_0000, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'h0800, 1'b0, EXP_BYTES, 3, 32'hE0A0_8000, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'hFFFF, 1'b0, EXP_BYTES, 3, 32'hEFBF_BF00, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'hD800, 1'b0, EXP_NONE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'hDC00, 1'b0, EXP_BYTES, 4, 32'hF090_8080, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'hDBFF, 1'b0, EXP_NONE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'hDFFF, 1'b1, EXP_BYTES, 4, 32'hF48F_BFBF, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'hD800, 1'b1, EXP_BARE, 0, '0, ST_HIGH_END)};
		dir_tab = {dir_tab, drow(1'b0, 16'hDC00, 1'b0, EXP_BARE, 0, '0, ST_UNP_LOW)};
		dir_tab = {dir_tab, drow(1'b0, 16'h0042, 1'b1, EXP_NONE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'hD800, 1'b0, EXP_NONE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'h0041, 1'b0, EXP_BARE, 0, '0, ST_UNP_HIGH)};
		dir_tab = {dir_tab, drow(1'b0, 16'hFFFF, 1'b1, EXP_NONE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b0, 16'hD801, 1'b0, EXP_NONE, 0, '0, ST_OK)};
		// unpaired high wins over a high surrogate on the last unit
		dir_tab = {dir_tab, drow(1'b0, 16'hD802, 1'b1, EXP_BARE, 0, '0, ST_UNP_HIGH)};
		dir_tab = {dir_tab, drow(1'b0, 16'h0000, 1'b1, EXP_BYTES, 1, 32'h0000_0000, ST_OK)};
		// ignore mode: bad surrogates vanish, empty endings give a bare marker
		dir_tab = {dir_tab, drow(1'b1, 16'hDC05, 1'b0, EXP_NONE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b1, 16'hD800, 1'b0, EXP_NONE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b1, 16'h0041, 1'b0, EXP_BYTES, 1, 32'h4100_0000, ST_OK)};
		dir_tab = {dir_tab, drow(1'b1, 16'hDBFF, 1'b1, EXP_BARE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b1, 16'hD83D, 1'b0, EXP_PRED, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b1, 16'hDE00, 1'b1, EXP_PRED, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b1, 16'hD800, 1'b0, EXP_NONE, 0, '0, ST_OK)};
		dir_tab = {dir_tab, drow(1'b1, 16'hD800, 1'b1, EXP_BARE, 0, '0, ST_OK)};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].mode != lenient)
				set_mode(dir_tab[i].mode);
			send_unit(dir_tab[i], $urandom_range(0, 16));
		end

		for (int ph = 0; ph < 4; ph++) begin
			int goal;
			set_mode(ph % 2 == 1);
			// long result-side hold while units keep coming
			if (ph == 1)
				hold_req = 1'b1;
			goal = units_sent + 22;
			while (units_sent < goal)
				send_string($urandom_range(1, 8), $urandom_range(0, 2) == 0);
		end

		drain_and_settle();
		$display("covered %0d code units (%0d random strings) and %0d result items",
			units_sent, strings_sent, results_seen);
		$display("strict and ignore modes over %0d mode writes, one long output hold",
			cfg_writes);
		if (mismatches == 0 && utf8_due.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
